// ===== rtl/psat_pkg.sv =====
// ============================================================================
// psat_pkg: shared types and constants for the polygon collision core
// Holds the request and response words, sequencer states and the fixed sizes.
// ============================================================================
package psat_pkg;

   localparam int MaxVertices = 16;
   localparam int CntW        = $clog2(MaxVertices + 1);
   localparam int AddrW       = $clog2(2 * MaxVertices);
   localparam int NormOne     = 16384;

   typedef struct packed {
      logic        opcode;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic        last;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [16:0] depth;
      logic [15:0] normal_x;
      logic [15:0] normal_y;
      logic        edge_owner;
      logic [3:0]  edge_index;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EDGE_RD0,
      ST_EDGE_RD1,
      ST_EDGE_DIFF,
      ST_EDGE_LEN,
      ST_SQRT,
      ST_DIV_X,
      ST_DIV_Y,
      ST_PROJ_RD,
      ST_PROJ,
      ST_GAP,
      ST_NEXT,
      ST_DONE
   } state_type;

   // Handshake between sequencer and divider.
   typedef struct packed {
      logic        go;
      logic [38:0] num;
      logic [25:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [14:0] quo;
   } div_rsp_type;

endpackage

// ===== rtl/psat_ram.sv =====
// ============================================================================
// psat_ram: generic single-port RAM
// One write or one read each cycle; the read data is registered.
// ============================================================================
module psat_ram #(
   parameter int Width = 32,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/psat_sqrt.sv =====
// ============================================================================
// psat_sqrt: iterative integer square root
// Produces floor(sqrt(n)) of a 50-bit value, one result bit per cycle.
// ============================================================================
module psat_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [49:0] n,
   output logic        done,
   output logic [24:0] root
);
   import psat_pkg::*;

   logic [25:0] rem_ff, rem_in;
   logic [49:0] src_ff, src_in;
   logic [24:0] res_ff, res_in;
   logic [4:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [27:0] cur;
   logic [27:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      src_in  = src_ff;
      res_in  = res_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      // Trial subtraction of (4*root+1) against the remainder with the next
      // two bits of the operand brought in.
      cur   = {rem_ff, src_ff[49:48]};
      trial = {1'b0, res_ff, 2'b01};
      if (go) begin
         rem_in  = '0;
         src_in  = n;
         res_in  = '0;
         step_in = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         src_in = src_ff << 2;
         if (cur >= trial) begin
            rem_in = 26'(cur - trial);
            res_in = {res_ff[23:0], 1'b1};
         end else begin
            rem_in = cur[25:0];
            res_in = {res_ff[23:0], 1'b0};
         end
         step_in = step_ff + 5'd1;
         if (step_ff == 5'd24) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      src_ff  <= src_in;
      res_ff  <= res_in;
      step_ff <= step_in;
   end

   assign done = done_ff;
   assign root = res_ff;

endmodule

// ===== rtl/psat_div.sv =====
// ============================================================================
// psat_div: iterative restoring divider
// Quotient of a 39-bit numerator by a 26-bit divisor, saturated to NormOne.
// ============================================================================
module psat_div (
   input  logic                      clock,
   input  logic                      reset,
   input  psat_pkg::div_req_type     dreq,
   output psat_pkg::div_rsp_type     drsp
);
   import psat_pkg::*;

   logic [25:0] rem_ff, rem_in;
   logic [38:0] num_ff, num_in;
   logic [25:0] den_ff, den_in;
   logic [38:0] quo_ff, quo_in;
   logic [5:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [26:0] shifted;

   always_comb begin
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, num_ff[38]};
      if (dreq.go) begin
         rem_in  = '0;
         num_in  = dreq.num;
         den_in  = dreq.den;
         quo_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = 26'(shifted - {1'b0, den_ff});
            quo_in = {quo_ff[37:0], 1'b1};
         end else begin
            rem_in = shifted[25:0];
            quo_in = {quo_ff[37:0], 1'b0};
         end
         step_in = step_ff + 6'd1;
         if (step_ff == 6'd38) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
   end

   assign drsp.done = done_ff;
   assign drsp.quo  = (quo_ff > 39'(NormOne)) ? 15'(NormOne) : quo_ff[14:0];

endmodule

// ===== rtl/polygon_sat_collision_core.sv =====
// ============================================================================
// polygon_sat_collision_core: separating-axis test for two convex polygons
// Stores vertex words of A and B, then projects both on each edge normal,
// stopping at a separating axis, else reporting the axis of least overlap.
// ============================================================================
//  channel | ports                      | handshake
//  request | req_word                   | start && !busy
//  result  | rsp_word                   | rsp_strobe, one cycle, no stall
//
// A vertex word is held in a register, then written to the vertex RAM; the
// walk starts once the word with last set is stored. Each edge reads and
// differences its two vertices, takes the root, runs both divides on one
// shared divider, projects A and B over the single-port vertex RAM and checks
// the gap; a zero-length edge skips the rest. The done state forms the result,
// registered with the strobe. Reset clears the counts and the sequencer.
// The result receiver cannot stall; busy stays high until the result is out.
module polygon_sat_collision_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  psat_pkg::req_type req_word,
   output logic              rsp_strobe,
   output psat_pkg::rsp_type rsp_word
);
   import psat_pkg::*;

   state_type state_ff, state_in;

   logic [CntW-1:0]  count_a_ff, count_a_in;
   logic [CntW-1:0]  count_b_ff, count_b_in;
   logic             wr_pend_ff, wr_pend_in;
   logic             last_ff, last_in;
   req_type          hold_ff, hold_in;

   // Edge walk.
   logic             own_ff, own_in;
   logic [CntW-1:0]  idx_ff, idx_in;
   logic             found_ff, found_in;
   logic             apart_ff, apart_in;
   logic signed [16:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [31:0]      p_ff, p_in;
   logic [24:0]      len_ff, len_in;
   logic signed [15:0] nx_ff, nx_in, ny_ff, ny_in;

   // Projection walk.
   logic             pown_ff, pown_in;
   logic [CntW-1:0]  pidx_ff, pidx_in;
   logic             pfirst_ff, pfirst_in;
   logic signed [33:0] mina_ff, mina_in, maxa_ff, maxa_in;
   logic signed [33:0] minb_ff, minb_in, maxb_ff, maxb_in;

   logic [34:0]      best_ff, best_in;
   logic signed [15:0] bnx_ff, bnx_in, bny_ff, bny_in;
   logic             bown_ff, bown_in;
   logic [3:0]       bidx_ff, bidx_in;

   rsp_type          rsp_ff, rsp_in;
   logic             strobe_ff, strobe_in;

   // Memory port.
   logic             ram_we;
   logic [AddrW-1:0] ram_addr;
   logic [31:0]      ram_wd, ram_rd;

   // Shared units.
   logic             sq_go, sq_done;
   logic [24:0]      sq_root;
   logic [49:0]      sq_n;
   div_req_type      dreq;
   div_rsp_type      drsp;

   logic [CntW-1:0]  n_cur, nxt_idx, pn_cur;
   logic signed [33:0] dot, gap;
   logic [34:0]      mag;
   logic [34:0]      rounded;
   logic             accept;
   logic [33:0]      dy_sq, dx_sq;
   logic [16:0]      adx, ady;

   assign accept = start && !busy;

   psat_ram #(.Width(32), .Depth(2 * MaxVertices)) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .addr   (ram_addr),
      .wr_data(ram_wd),
      .rd_data(ram_rd)
   );

   psat_sqrt u_sqrt (
      .clock(clock),
      .reset(reset),
      .go   (sq_go),
      .n    (sq_n),
      .done (sq_done),
      .root (sq_root)
   );

   psat_div u_div (
      .clock(clock),
      .reset(reset),
      .dreq (dreq),
      .drsp (drsp)
   );

   assign n_cur   = own_ff ? count_b_ff : count_a_ff;
   assign nxt_idx = (idx_ff + 1'b1 == n_cur) ? '0 : CntW'(idx_ff + 1'b1);
   assign pn_cur  = pown_ff ? count_b_ff : count_a_ff;
   assign dx_sq   = 34'(dx_ff * dx_ff);
   assign dy_sq   = 34'(dy_ff * dy_ff);
   assign sq_n    = 50'(dx_sq + dy_sq) << 16;
   assign adx     = dx_ff[16] ? 17'(-dx_ff) : 17'(dx_ff);
   assign ady     = dy_ff[16] ? 17'(-dy_ff) : 17'(dy_ff);
   assign dot     = 34'($signed(ram_rd[15:0]) * nx_ff) + 34'($signed(ram_rd[31:16]) * ny_ff);
   assign gap     = (mina_ff < minb_ff) ? 34'(minb_ff - maxa_ff) : 34'(mina_ff - maxb_ff);
   assign mag     = 35'(-{gap[33], gap});
   assign rounded = 35'(best_ff + 35'd8192) >> 14;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            // The closing word has been stored, so the counts are final.
            if (last_ff && !wr_pend_ff) begin
               if (count_a_ff == '0 || count_b_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_EDGE_RD0;
               end
            end
         end
         ST_EDGE_RD0:  state_in = ST_EDGE_RD1;
         ST_EDGE_RD1:  state_in = ST_EDGE_DIFF;
         ST_EDGE_DIFF: state_in = ST_EDGE_LEN;
         ST_EDGE_LEN: begin
            if (dx_ff == '0 && dy_ff == '0) begin
               state_in = ST_NEXT;
            end else begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT:    if (sq_done) state_in = ST_DIV_X;
         ST_DIV_X:   if (drsp.done) state_in = ST_DIV_Y;
         ST_DIV_Y:   if (drsp.done) state_in = ST_PROJ_RD;
         ST_PROJ_RD: state_in = ST_PROJ;
         ST_PROJ: begin
            if (pown_ff && pidx_ff + 1'b1 == count_b_ff) begin
               state_in = ST_GAP;
            end else begin
               state_in = ST_PROJ_RD;
            end
         end
         ST_GAP: begin
            if (!gap[33] && gap != '0) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (own_ff && idx_ff + 1'b1 == count_b_ff) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_EDGE_RD0;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      wr_pend_in = 1'b0;
      last_in    = last_ff;
      hold_in    = hold_ff;
      own_in     = own_ff;
      idx_in     = idx_ff;
      found_in   = found_ff;
      apart_in   = apart_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      p_in       = p_ff;
      len_in     = len_ff;
      nx_in      = nx_ff;
      ny_in      = ny_ff;
      pown_in    = pown_ff;
      pidx_in    = pidx_ff;
      pfirst_in  = pfirst_ff;
      mina_in    = mina_ff;
      maxa_in    = maxa_ff;
      minb_in    = minb_ff;
      maxb_in    = maxb_ff;
      best_in    = best_ff;
      bnx_in     = bnx_ff;
      bny_in     = bny_ff;
      bown_in    = bown_ff;
      bidx_in    = bidx_ff;
      rsp_in     = rsp_ff;
      strobe_in  = 1'b0;
      ram_we     = 1'b0;
      ram_addr   = '0;
      ram_wd     = {hold_ff.pos_y, hold_ff.pos_x};
      sq_go      = 1'b0;
      dreq.go    = 1'b0;
      dreq.num   = '0;
      dreq.den   = 26'(len_ff);
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               hold_in    = req_word;
               last_in    = req_word.last;
               wr_pend_in = 1'b1;
            end
            if (wr_pend_ff) begin
               // Store the word unless its polygon is full.
               if (!hold_ff.opcode && count_a_ff < CntW'(MaxVertices)) begin
                  ram_we     = 1'b1;
                  ram_addr   = AddrW'(count_a_ff);
                  count_a_in = count_a_ff + 1'b1;
               end else if (hold_ff.opcode && count_b_ff < CntW'(MaxVertices)) begin
                  ram_we     = 1'b1;
                  ram_addr   = AddrW'(MaxVertices) + AddrW'(count_b_ff);
                  count_b_in = count_b_ff + 1'b1;
               end
               own_in   = 1'b0;
               idx_in   = '0;
               found_in = 1'b0;
               apart_in = 1'b0;
            end
         end
         ST_EDGE_RD0: begin
            ram_addr = own_ff ? AddrW'(MaxVertices) + AddrW'(idx_ff) : AddrW'(idx_ff);
         end
         ST_EDGE_RD1: begin
            ram_addr = own_ff ? AddrW'(MaxVertices) + AddrW'(nxt_idx) : AddrW'(nxt_idx);
            p_in     = ram_rd;
         end
         ST_EDGE_DIFF: begin
            dx_in = 17'($signed(ram_rd[15:0])) - 17'($signed(p_ff[15:0]));
            dy_in = 17'($signed(ram_rd[31:16])) - 17'($signed(p_ff[31:16]));
         end
         ST_EDGE_LEN: begin
            if (dx_ff != '0 || dy_ff != '0) begin
               sq_go = 1'b1;
            end
         end
         ST_SQRT: begin
            if (sq_done) begin
               len_in   = sq_root;
               dreq.go  = 1'b1;
               dreq.den = 26'(sq_root);
               dreq.num = (39'(ady) << 22) + 39'(sq_root >> 1);
            end
         end
         ST_DIV_X: begin
            if (drsp.done) begin
               nx_in    = dy_ff < 0 ? 16'(drsp.quo) : -16'(drsp.quo);
               dreq.go  = 1'b1;
               dreq.num = (39'(adx) << 22) + 39'(len_ff >> 1);
            end
         end
         ST_DIV_Y: begin
            if (drsp.done) begin
               ny_in     = dx_ff < 0 ? -16'(drsp.quo) : 16'(drsp.quo);
               pown_in   = 1'b0;
               pidx_in   = '0;
               pfirst_in = 1'b1;
            end
         end
         ST_PROJ_RD: begin
            ram_addr = pown_ff ? AddrW'(MaxVertices) + AddrW'(pidx_ff) : AddrW'(pidx_ff);
         end
         ST_PROJ: begin
            if (!pown_ff) begin
               if (pfirst_ff || dot < mina_ff) mina_in = dot;
               if (pfirst_ff || dot > maxa_ff) maxa_in = dot;
            end else begin
               if (pfirst_ff || dot < minb_ff) minb_in = dot;
               if (pfirst_ff || dot > maxb_ff) maxb_in = dot;
            end
            if (pidx_ff + 1'b1 == pn_cur) begin
               pown_in   = 1'b1;
               pidx_in   = '0;
               pfirst_in = 1'b1;
            end else begin
               pidx_in   = pidx_ff + 1'b1;
               pfirst_in = 1'b0;
            end
         end
         ST_GAP: begin
            if (!gap[33] && gap != '0) begin
               apart_in = 1'b1;
            end else if (!found_ff || mag < best_ff) begin
               found_in = 1'b1;
               best_in  = mag;
               bnx_in   = nx_ff;
               bny_in   = ny_ff;
               bown_in  = own_ff;
               bidx_in  = 4'(idx_ff);
            end
         end
         ST_NEXT: begin
            if (!own_ff && idx_ff + 1'b1 == count_a_ff) begin
               own_in = 1'b1;
               idx_in = '0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DONE: begin
            strobe_in  = 1'b1;
            count_a_in = '0;
            count_b_in = '0;
            last_in    = 1'b0;
            rsp_in     = '0;
            if (found_ff && !apart_ff) begin
               rsp_in.hit        = 1'b1;
               rsp_in.depth      = (rounded > 35'd131071) ? 17'd131071 : rounded[16:0];
               rsp_in.normal_x   = bnx_ff;
               rsp_in.normal_y   = bny_ff;
               rsp_in.edge_owner = bown_ff;
               rsp_in.edge_index = bidx_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_a_ff <= '0;
         count_b_ff <= '0;
         wr_pend_ff <= 1'b0;
         last_ff    <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_a_ff <= count_a_in;
         count_b_ff <= count_b_in;
         wr_pend_ff <= wr_pend_in;
         last_ff    <= last_in;
         strobe_ff  <= strobe_in;
      end
      hold_ff   <= hold_in;
      own_ff    <= own_in;
      idx_ff    <= idx_in;
      found_ff  <= found_in;
      apart_ff  <= apart_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      p_ff      <= p_in;
      len_ff    <= len_in;
      nx_ff     <= nx_in;
      ny_ff     <= ny_in;
      pown_ff   <= pown_in;
      pidx_ff   <= pidx_in;
      pfirst_ff <= pfirst_in;
      mina_ff   <= mina_in;
      maxa_ff   <= maxa_in;
      minb_ff   <= minb_in;
      maxb_ff   <= maxb_in;
      best_ff   <= best_in;
      bnx_ff    <= bnx_in;
      bny_ff    <= bny_in;
      bown_ff   <= bown_in;
      bidx_ff   <= bidx_in;
      rsp_ff    <= rsp_in;
   end

   // A word is taken only in idle with no store pending.
   assign busy       = (state_ff != ST_IDLE) || wr_pend_ff || last_ff;
   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

`ifndef SYNTHESIS
   a_counts_bound: assert property (@(posedge clock) disable iff (reset)
      count_a_ff <= CntW'(MaxVertices) && count_b_ff <= CntW'(MaxVertices))
      else $error("vertex count beyond capacity");
   a_strobe_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> count_a_ff == '0 && count_b_ff == '0)
      else $error("counts not cleared with result");
   a_no_hit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_word.hit |-> rsp_word.depth == '0)
      else $error("depth nonzero without hit");
`endif

endmodule

// ===== dv/polygon_sat_collision_core_tb.sv =====
// ============================================================================
// polygon_sat_collision_core_tb: self-checking bench for the collision core
// Sends vertex words of two polygons and predicts each separating-axis result
// with a bit-accurate fixed-point model; results are compared field by field.
// ============================================================================
module polygon_sat_collision_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import psat_pkg::*;

   localparam int WatchdogLimit = 200000;
   localparam int SettleCycles  = 64;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_word = '0;
   logic    rsp_strobe;
   rsp_type rsp_word;

   polygon_sat_collision_core u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word)
   );

   always #1 clock = ~clock;

   // Predictor state: the two vertex lists and their counts.
   logic signed [15:0] poly_x[2][MaxVertices];
   logic signed [15:0] poly_y[2][MaxVertices];
   int unsigned        poly_cnt[2];
   rsp_type            expected_hits[$];

   int  fail_count = 0;
   int  words_sent = 0;
   int  hits_seen  = 0;
   int  results_seen = 0;
   int  idle_cycles = 0;
   int  send_idle_pct = 0;

   function automatic longint unsigned isqrt(longint unsigned n);
      longint unsigned res = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint normal_part(longint num, longint unsigned len8);
      longint unsigned mag;
      longint unsigned q;
      mag = longint'(num < 0 ? -num : num) << 22;
      q = (mag + len8 / 2) / len8;
      if (q > NormOne) q = NormOne;
      return num < 0 ? -longint'(q) : longint'(q);
   endfunction

   // Applies one vertex word to the predictor; returns 1 when a result is due.
   function automatic bit predict_contact(input req_type w, output rsp_type r);
      int unsigned own, n, idx, nxt, e, total, p, i;
      longint dx, dy, nx, ny, d, gap;
      longint mn[2], mx[2];
      longint unsigned len8, mag, best;
      bit found, apart;
      r = '0;
      own = w.opcode;
      if (poly_cnt[own] < MaxVertices) begin
         poly_x[own][poly_cnt[own]] = w.pos_x;
         poly_y[own][poly_cnt[own]] = w.pos_y;
         poly_cnt[own]++;
      end
      if (!w.last) return 1'b0;
      found = 0;
      apart = 0;
      best = 0;
      total = (poly_cnt[0] == 0 || poly_cnt[1] == 0) ? 0 : poly_cnt[0] + poly_cnt[1];
      for (e = 0; e < total && !apart; e++) begin
         own = e < poly_cnt[0] ? 0 : 1;
         n   = poly_cnt[own];
         idx = own ? e - poly_cnt[0] : e;
         nxt = (idx + 1 == n) ? 0 : idx + 1;
         dx = longint'(poly_x[own][nxt]) - longint'(poly_x[own][idx]);
         dy = longint'(poly_y[own][nxt]) - longint'(poly_y[own][idx]);
         if (dx == 0 && dy == 0) continue;
         len8 = isqrt(longint'(dx * dx + dy * dy) << 16);
         nx = normal_part(-dy, len8);
         ny = normal_part(dx, len8);
         for (p = 0; p < 2; p++) begin
            for (i = 0; i < poly_cnt[p]; i++) begin
               d = longint'(poly_x[p][i]) * nx + longint'(poly_y[p][i]) * ny;
               if (i == 0 || d < mn[p]) mn[p] = d;
               if (i == 0 || d > mx[p]) mx[p] = d;
            end
         end
         gap = (mn[0] < mn[1]) ? mn[1] - mx[0] : mn[0] - mx[1];
         if (gap > 0) begin
            apart = 1;
            break;
         end
         mag = -gap;
         if (!found || mag < best) begin
            found = 1;
            best = mag;
            r.normal_x = nx[15:0];
            r.normal_y = ny[15:0];
            r.edge_owner = own[0];
            r.edge_index = idx[3:0];
         end
      end
      poly_cnt[0] = 0;
      poly_cnt[1] = 0;
      if (apart || !found) begin
         r = '0;
      end else begin
         best = (best + 8192) >> 14;
         if (best > 131071) best = 131071;
         r.hit = 1'b1;
         r.depth = best[16:0];
      end
      return 1'b1;
   endfunction

   // Result checker and watchdog, sampled at the rising edge.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if ((start && !busy) || rsp_strobe) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("FAIL polygon_sat_collision_core");
            $finish;
         end
         if (rsp_strobe) begin
            results_seen <= results_seen + 1;
            if (rsp_word.hit) hits_seen <= hits_seen + 1;
            if (expected_hits.size() == 0) begin
               $error("unexpected result word %h", rsp_word);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_hits.pop_front();
               if (rsp_word !== want) begin
                  fail_count <= fail_count + 1;
                  if (rsp_word.hit !== want.hit)
                     $error("hit: expected %0d actual %0d", want.hit, rsp_word.hit);
                  if (rsp_word.depth !== want.depth)
                     $error("depth: expected %0d actual %0d", want.depth, rsp_word.depth);
                  if (rsp_word.normal_x !== want.normal_x)
                     $error("normal_x: expected %0d actual %0d",
                            $signed(want.normal_x), $signed(rsp_word.normal_x));
                  if (rsp_word.normal_y !== want.normal_y)
                     $error("normal_y: expected %0d actual %0d",
                            $signed(want.normal_y), $signed(rsp_word.normal_y));
                  if (rsp_word.edge_owner !== want.edge_owner)
                     $error("edge_owner: expected %0d actual %0d",
                            want.edge_owner, rsp_word.edge_owner);
                  if (rsp_word.edge_index !== want.edge_index)
                     $error("edge_index: expected %0d actual %0d",
                            want.edge_index, rsp_word.edge_index);
               end
            end
         end
      end
   end

   // Sends one vertex word; start stays high across back-to-back words.
   task automatic send_vertex(input bit owner, input logic [15:0] x, input logic [15:0] y,
                              input bit fin);
      rsp_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      req_word <= '{opcode: owner, pos_x: x, pos_y: y, last: fin};
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (predict_contact('{opcode: owner, pos_x: x, pos_y: y, last: fin}, r))
         expected_hits.insert(expected_hits.size(), r);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(negedge clock);
      while (expected_hits.size() != 0) @(negedge clock);
   endtask

   // Regular polygon-ish shape of n vertices around a center, convex order.
   task automatic send_shape(input bit owner, input int n, input int cx, input int cy,
                             input int rad, input bit fin);
      int k;
      real ang;
      for (k = 0; k < n; k++) begin
         ang = 6.283185307 * k / n;
         send_vertex(owner, 16'(cx + int'(rad * $cos(ang))),
                     16'(cy + int'(rad * $sin(ang))), fin && (k == n - 1));
      end
   endtask

   task automatic test_directed();
      // Overlapping squares, separated squares, extremes.
      send_shape(1'b0, 4, 0, 0, 160, 1'b0);
      send_shape(1'b1, 4, 80, 40, 160, 1'b1);
      send_shape(1'b0, 4, 0, 0, 16, 1'b0);
      send_shape(1'b1, 4, 2000, 0, 16, 1'b1);
      send_vertex(1'b0, 16'h8000, 16'h8000, 1'b0);
      send_vertex(1'b0, 16'h7fff, 16'h8000, 1'b0);
      send_vertex(1'b0, 16'h7fff, 16'h7fff, 1'b0);
      send_vertex(1'b1, 16'h8000, 16'h7fff, 1'b0);
      send_vertex(1'b1, 16'h0000, 16'h8000, 1'b0);
      send_vertex(1'b1, 16'h7fff, 16'h7fff, 1'b1);
      // Empty polygon B, then all edges of zero length.
      send_vertex(1'b0, 16'd5, 16'd5, 1'b1);
      send_vertex(1'b0, 16'd7, 16'd7, 1'b0);
      send_vertex(1'b1, 16'd7, 16'd7, 1'b0);
      send_vertex(1'b1, 16'd7, 16'd7, 1'b1);
      // A lone word without last gives nothing until the closing word.
      send_vertex(1'b1, 16'hffff, 16'h0001, 1'b0);
      send_vertex(1'b0, 16'h0001, 16'hffff, 1'b1);
   endtask

   task automatic test_store_full();
      // Twenty vertices per polygon: the extra ones are dropped, and the
      // closing dropped word still starts the test.
      send_shape(1'b0, 20, 0, 0, 400, 1'b0);
      send_shape(1'b1, 20, 100, -50, 400, 1'b1);
      drain_results();
   endtask

   task automatic test_random(input int words);
      int goal;
      int na, nb, sel;
      goal = words_sent + words;
      while (words_sent < goal) begin
         sel = $urandom_range(9);
         na = $urandom_range(1, 6);
         nb = $urandom_range(1, 6);
         if (sel < 7) begin
            send_shape(1'b0, na, $signed($urandom_range(2000)) - 1000,
                       $signed($urandom_range(2000)) - 1000,
                       int'($urandom_range(4, 800)), 1'b0);
            send_shape(1'b1, nb, $signed($urandom_range(2000)) - 1000,
                       $signed($urandom_range(2000)) - 1000,
                       int'($urandom_range(4, 800)), 1'b1);
         end else begin
            // Noise: raw words of any value, closed at random.
            repeat (na + nb)
               send_vertex(1'($urandom_range(1)), 16'($urandom()), 16'($urandom()),
                           $urandom_range(3) == 0);
            send_vertex(1'($urandom_range(1)), 16'($urandom()), 16'($urandom()), 1'b1);
         end
      end
   endtask

   initial begin
      poly_cnt[0] = 0;
      poly_cnt[1] = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 36;
      test_directed();
      drain_results();
      test_store_full();
      test_random(700);
      send_idle_pct = 47;
      test_random(650);
      send_idle_pct = 0;
      test_random(650);
      drain_results();
      repeat (SettleCycles) @(negedge clock);
      $display("Sent %0d vertex words; %0d results checked, %0d of them contacts.",
               words_sent, results_seen, hits_seen);
      if (fail_count == 0 && expected_hits.size() == 0) begin
         $display("PASS polygon_sat_collision_core");
      end else begin
         $display("FAIL polygon_sat_collision_core");
      end
      $finish;
   end

endmodule
